// File: rtl/wsfp_pkg.sv
`timescale 1ns / 1ps
package wsfp_pkg;

  localparam int unsigned LEN_W       = 63;
  localparam int unsigned BL_W        = 63;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // header byte fields and length codes
  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] OPC_MASK    = 8'h0F;
  localparam logic [7:0] LEN7_MASK   = 8'h7F;
  localparam logic [6:0] LEN7_MAX    = 7'd125;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;

  // one parsed beat on its way from front to back
  typedef struct packed {
    logic              payload_valid;
    logic [7:0]        raw_byte;
    logic [7:0]        key_byte;
    logic              frame_end;
    logic              message_end;
    logic [3:0]        msg_opcode;
    logic [2:0]        rsv_bits;
    logic              is_masked;
    logic [LEN_W-1:0]  frame_length;
  } wsfp_item_t;

endpackage

// File: rtl/wsfp_if.sv
`timescale 1ns / 1ps
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsfp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       payload_valid;
  logic [7:0]                 payload_byte;
  logic                       frame_end;
  logic                       message_end;
  logic [3:0]                 msg_opcode;
  logic [2:0]                 rsv_bits;
  logic                       is_masked;
  logic [wsfp_pkg::LEN_W-1:0] frame_length;

  modport source (output valid, output payload_valid, output payload_byte,
                  output frame_end, output message_end, output msg_opcode,
                  output rsv_bits, output is_masked, output frame_length,
                  input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input frame_end, input message_end, input msg_opcode,
                  input rsv_bits, input is_masked, input frame_length,
                  output ready);
endinterface

// File: rtl/websocket_frame_parser_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   byte_in[7:0]
// out_ch    out  valid/ready   payload_valid, payload_byte[7:0], frame_end, message_end,
//                              msg_opcode[3:0], rsv_bits[2:0], is_masked, frame_length[62:0]
//
// One byte per cycle sustained while out_ch is not stalled; one result beat per input beat.
// An accepted beat is written into the queue, then into the output register, before out_ch shows it.
// A 4-entry queue sits between the header parser and the output register, so in_ch
// takes up to four more beats while out_ch stalls (three when one is already queued).
// rst_n is synchronous; after reset the parser waits for a frame header byte.
module websocket_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  wsfp_in_if.sink     in_ch,
  wsfp_out_if.source  out_ch
);

  wsfp_pkg::wsfp_item_t push_item;
  wsfp_pkg::wsfp_item_t head_item;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_not_empty;

  wsfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.byte_in),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (push),
    .q_item   (push_item)
  );

  wsfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  wsfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_item),
    .q_pop       (pop),
    .out_ch      (out_ch)
  );

endmodule

// File: rtl/wsfp_front.sv
`timescale 1ns / 1ps
module wsfp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 q_push,
  output wsfp_pkg::wsfp_item_t q_item
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEN7    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASKKEY = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]                   phase_r, phase_nxt;
  logic [wsfp_pkg::BL_W-1:0]    left_r, left_nxt, left_dec;
  logic [31:0]                  key_r, key_nxt;
  logic [1:0]                   kidx_r, kidx_nxt;
  logic                         cont_r, cont_nxt;
  logic                         fin_r, fin_nxt;
  logic                         mask_r, mask_nxt;
  logic [3:0]                   opc_r, opc_nxt;
  logic [2:0]                   rsv_r, rsv_nxt;
  logic [wsfp_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                         done;
  logic                         pvalid;
  logic [7:0]                   raw;
  logic [7:0]                   kbyte;
  logic [7:0]                   key_sel;
  logic [6:0]                   l7;
  logic [3:0]                   op;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : '0;
  assign l7       = in_byte[6:0] & wsfp_pkg::LEN7_MASK[6:0];
  assign op       = in_byte[3:0] & wsfp_pkg::OPC_MASK[3:0];

  always_comb begin
    case (kidx_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    key_nxt   = key_r;
    kidx_nxt  = kidx_r;
    cont_nxt  = cont_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    opc_nxt   = opc_r;
    rsv_nxt   = rsv_r;
    len_nxt   = len_r;
    done      = 1'b0;
    pvalid    = 1'b0;
    raw       = 8'd0;
    kbyte     = 8'd0;
    case (phase_r)
      PH_LEN7: begin
        mask_nxt = (in_byte & wsfp_pkg::FIN_BIT) != 8'd0;
        if (l7 <= wsfp_pkg::LEN7_MAX) begin
          len_nxt = {{(wsfp_pkg::LEN_W-7){1'b0}}, l7};
          if (mask_nxt) begin
            phase_nxt = PH_MASKKEY;
            left_nxt  = wsfp_pkg::BL_W'(4);
            key_nxt   = 32'd0;
          end else if (l7 == 7'd0) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = {{(wsfp_pkg::BL_W-7){1'b0}}, l7};
          end
        end else begin
          len_nxt   = '0;
          left_nxt  = (l7 == wsfp_pkg::LEN_CODE_16) ? wsfp_pkg::BL_W'(2)
                                                    : wsfp_pkg::BL_W'(8);
          phase_nxt = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        len_nxt  = {len_r[wsfp_pkg::LEN_W-9:0], in_byte};
        left_nxt = left_dec;
        if (left_dec == '0) begin
          if (mask_r) begin
            phase_nxt = PH_MASKKEY;
            left_nxt  = wsfp_pkg::BL_W'(4);
            key_nxt   = 32'd0;
          end else if (len_nxt == '0) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = len_nxt;
          end
        end
      end
      PH_MASKKEY: begin
        key_nxt  = {key_r[23:0], in_byte};
        left_nxt = left_dec;
        if (left_dec == '0) begin
          if (len_r == '0) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = len_r;
          end
        end
      end
      PH_PAYLOAD: begin
        pvalid   = 1'b1;
        raw      = in_byte;
        kbyte    = mask_r ? key_sel : 8'd0;
        kidx_nxt = kidx_r + 2'd1;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          done = 1'b1;
        end
      end
      default: begin
        // header byte; unreachable phase codes land here too
        fin_nxt = (in_byte & wsfp_pkg::FIN_BIT) != 8'd0;
        rsv_nxt = in_byte[6:4] & wsfp_pkg::RSV_MASK[6:4];
        if (!cont_r && op != 4'd0) begin
          opc_nxt = op;
        end
        phase_nxt = PH_LEN7;
      end
    endcase
    if (done) begin
      kidx_nxt  = 2'd0;
      left_nxt  = '0;
      phase_nxt = PH_HEADER;
      cont_nxt  = !fin_r;
    end
  end

  always_comb begin
    q_item.payload_valid = pvalid;
    q_item.raw_byte      = raw;
    q_item.key_byte      = kbyte;
    q_item.frame_end     = done;
    q_item.message_end   = done && fin_r;
    q_item.msg_opcode    = opc_nxt;
    q_item.rsv_bits      = rsv_nxt;
    q_item.is_masked     = mask_nxt;
    q_item.frame_length  = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      left_r  <= '0;
      key_r   <= 32'd0;
      kidx_r  <= 2'd0;
      cont_r  <= 1'b0;
      fin_r   <= 1'b0;
      mask_r  <= 1'b0;
      opc_r   <= 4'd0;
      rsv_r   <= 3'd0;
      len_r   <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
      cont_r  <= cont_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      opc_r   <= opc_nxt;
      rsv_r   <= rsv_nxt;
      len_r   <= len_nxt;
    end
  end

`ifndef SYNTHESIS
  a_msg_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.message_end |-> q_item.frame_end)
    else $error("message end without frame end");
  a_unmasked_key: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.payload_valid && !q_item.is_masked |-> q_item.key_byte == 8'd0)
    else $error("key byte applied to unmasked frame");
  a_back_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && done |=> phase_r == PH_HEADER && kidx_r == 2'd0)
    else $error("frame end did not return to header phase");
`endif

endmodule

// File: rtl/wsfp_queue.sv
`timescale 1ns / 1ps
module wsfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wsfp_pkg::wsfp_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output wsfp_pkg::wsfp_item_t head_item
);

  wsfp_pkg::wsfp_item_t              mem_r [wsfp_pkg::QUEUE_DEPTH];
  logic [wsfp_pkg::QPTR_W-1:0]       wptr_r, wptr_nxt;
  logic [wsfp_pkg::QPTR_W-1:0]       rptr_r, rptr_nxt;
  logic [wsfp_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = cnt_r == wsfp_pkg::QCNT_W'(wsfp_pkg::QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_item = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wsfp_pkg::QCNT_W'(wsfp_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/wsfp_back.sv
`timescale 1ns / 1ps
module wsfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  wsfp_pkg::wsfp_item_t q_head,
  output logic                 q_pop,
  wsfp_out_if.source           out_ch
);

  logic                       ov_r;
  logic                       pv_r;
  logic [7:0]                 pbyte_r, pbyte_nxt;
  logic                       fend_r;
  logic                       mend_r;
  logic [3:0]                 opc_r;
  logic [2:0]                 rsv_r;
  logic                       mask_r;
  logic [wsfp_pkg::LEN_W-1:0] len_r;

  assign q_pop     = q_not_empty && (!ov_r || out_ch.ready);
  // unmask; non-payload beats carry zero raw and key bytes
  assign pbyte_nxt = q_head.raw_byte ^ q_head.key_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_pop) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pv_r    <= q_head.payload_valid;
      pbyte_r <= pbyte_nxt;
      fend_r  <= q_head.frame_end;
      mend_r  <= q_head.message_end;
      opc_r   <= q_head.msg_opcode;
      rsv_r   <= q_head.rsv_bits;
      mask_r  <= q_head.is_masked;
      len_r   <= q_head.frame_length;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.payload_valid = pv_r;
  assign out_ch.payload_byte  = pbyte_r;
  assign out_ch.frame_end     = fend_r;
  assign out_ch.message_end   = mend_r;
  assign out_ch.msg_opcode    = opc_r;
  assign out_ch.rsv_bits      = rsv_r;
  assign out_ch.is_masked     = mask_r;
  assign out_ch.frame_length  = len_r;

`ifndef SYNTHESIS
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> ov_r)
    else $error("popped beat not registered");
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !pv_r |-> pbyte_r == 8'd0)
    else $error("non-payload beat carries a byte");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |-> !q_pop)
    else $error("output beat overwritten while stalled");
`endif

endmodule
